// File: hdl/sliding_window_median_top_macros.svh
// Assertion macros for the sliding-window median filter.
// Included by sliding_window_median_top.sv; expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sliding window median check failed");

// Consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding window median check failed");

`else

`define SWM_ASSERT_NOW(label, ante, cons)
`define SWM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/swm_pkg.sv
// Shared types and constants for the sliding-window median filter.
// No dependencies; compiled first.
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int OUT_W          = 33;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;
  // Cells per group in the first level of the median readout tree.
  localparam int PICK_GRP       = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PICK1,
    ST_PICK2,
    ST_SUM
  } swm_state_t;

  // Broadcast from the controller to every sorted cell.
  typedef struct packed {
    logic                       load;
    logic                       full;
    logic signed [SAMPLE_W-1:0] rem_val;
    logic signed [SAMPLE_W-1:0] ins_val;
  } swm_upd_t;

  // Handed from one cell to the next: value after removal and its order flag.
  typedef struct packed {
    logic                       le;
    logic signed [SAMPLE_W-1:0] val;
  } swm_link_t;

endpackage

// File: hdl/swm_in_if.sv
// Input channel of the sliding-window median filter: one sample per beat.
// Depends on swm_pkg.
interface swm_in_if;
  import swm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

// File: hdl/swm_out_if.sv
// Result channel of the sliding-window median filter: one doubled median per beat.
// Depends on swm_pkg.
interface swm_out_if;
  import swm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface

// File: hdl/swm_cell.sv
// One cell of the sorted chain: holds one sample of the window in order.
// Depends on swm_pkg; instantiated in a row by sliding_window_median_top.
module swm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                               clk,
  input  swm_pkg::swm_upd_t                  upd,
  input  logic [CW-1:0]                      bcount,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] next_val,
  input  swm_pkg::swm_link_t                 prev_link,
  output logic signed [swm_pkg::SAMPLE_W-1:0] val,
  output swm_pkg::swm_link_t                 link
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] val_r;
  logic signed [SAMPLE_W-1:0] val_nxt;
  logic signed [SAMPLE_W-1:0] kept;
  logic                       below_rem;
  logic                       kept_valid;

  // Removal: cells at or above the evicted value take their upper neighbor.
  // Insertion: a cell above the new sample takes the new sample or its lower neighbor.
  always_comb begin
    below_rem  = $signed(val_r) < $signed(upd.rem_val);
    kept       = (upd.full && !below_rem) ? next_val : val_r;
    kept_valid = bcount > CW'(IDX);
    link.val   = kept;
    link.le    = kept_valid && ($signed(kept) <= $signed(upd.ins_val));
    if (link.le) begin
      val_nxt = kept;
    end else if (prev_link.le) begin
      val_nxt = upd.ins_val;
    end else begin
      val_nxt = prev_link.val;
    end
  end

  // Cell storage; contents beyond the fill count are don't-care.
  always_ff @(posedge clk) begin
    if (upd.load) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

// File: hdl/swm_pick.sv
// Two-stage registered select tree that reads the two middle cells of the chain.
// Depends on swm_pkg; instantiated by sliding_window_median_top.
module swm_pick #(
  parameter int WMAX = 64,
  parameter int AW   = 6
) (
  input  logic                                         clk,
  input  logic [WMAX-1:0][swm_pkg::SAMPLE_W-1:0]       vals,
  input  logic [AW-1:0]                                lo_idx,
  input  logic [AW-1:0]                                hi_idx,
  output logic signed [swm_pkg::SAMPLE_W-1:0]          lo_val,
  output logic signed [swm_pkg::SAMPLE_W-1:0]          hi_val
);
  import swm_pkg::*;

  localparam int NG = (WMAX + PICK_GRP - 1) / PICK_GRP;

  logic [SAMPLE_W-1:0] grp_lo     [NG];
  logic [SAMPLE_W-1:0] grp_hi     [NG];
  logic [SAMPLE_W-1:0] grp_lo_r   [NG];
  logic [SAMPLE_W-1:0] grp_hi_r   [NG];
  logic [SAMPLE_W-1:0] lo_nxt;
  logic [SAMPLE_W-1:0] hi_nxt;
  logic [SAMPLE_W-1:0] lo_val_r;
  logic [SAMPLE_W-1:0] hi_val_r;

  // First level: within each group, AND-OR the cell whose index matches.
  always_comb begin
    int k;
    for (int g = 0; g < NG; g++) begin
      grp_lo[g] = '0;
      grp_hi[g] = '0;
      for (int j = 0; j < PICK_GRP; j++) begin
        k = g * PICK_GRP + j;
        if (k < WMAX) begin
          if (AW'(k) == lo_idx) begin
            grp_lo[g] = grp_lo[g] | vals[k];
          end
          if (AW'(k) == hi_idx) begin
            grp_hi[g] = grp_hi[g] | vals[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_lo_r[g] <= grp_lo[g];
      grp_hi_r[g] <= grp_hi[g];
    end
  end

  // Second level: only one group carries a non-zero select, so OR them together.
  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      lo_nxt = lo_nxt | grp_lo_r[g];
      hi_nxt = hi_nxt | grp_hi_r[g];
    end
  end

  always_ff @(posedge clk) begin
    lo_val_r <= lo_nxt;
    hi_val_r <= hi_nxt;
  end

  assign lo_val = $signed(lo_val_r);
  assign hi_val = $signed(hi_val_r);

endmodule

// File: hdl/sliding_window_median_top.sv
// Top level of the sliding-window median filter: controller, arrival ring, sorted chain.
// Depends on swm_pkg, swm_in_if, swm_out_if, swm_cell, swm_pick and the macros header.
`include "sliding_window_median_top_macros.svh"

// Running median over the last window_size signed 32-bit samples. The window is kept
// twice: in arrival order in a ring memory, and in ascending order in a row of sorted
// cells that all update together, each cell looking only at its two neighbors. Once the
// window is full, every sample beat yields one result beat holding twice the median
// (the sum of the two middle samples), so the lowest bit is the one-half fraction.
// A sample beat with restart set empties the window before it is taken in; writing
// window_size (0 means 1, values above WINDOW_MAX saturate) also empties the window.
// An item runs through the ring read of the oldest sample and the sorted-chain update;
// when it yields a result it then runs through the registered median readout tree and
// the final add. A new sample is accepted as soon as the result is parked in the
// output register, so a slow sink stalls the block only while that register is still
// occupied. No clearing pass is run after reset.
module sliding_window_median_top #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  swm_in_if.sink                      in_bus,
  swm_out_if.source                   out_bus,
  input  logic                        cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]   cfg_wdata
);
  import swm_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;

  swm_state_t state_r, state_nxt;

  logic [CW-1:0]              w_r;
  logic [AW-1:0]              lo_r;
  logic [AW-1:0]              hi_r;
  logic [CW-1:0]              fill_r;
  logic [AW-1:0]              pos_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] ring_q_r;
  logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
  logic                       out_valid_r;
  logic signed [OUT_W-1:0]    out_data_r;

  logic                       in_take;
  logic                       full;
  logic                       emit;
  logic                       out_load;
  logic                       upd_load;
  logic [AW-1:0]              rd_addr;
  logic [CW-1:0]              bcount;
  logic [CW-1:0]              pos_inc;
  logic [XW-1:0]              cfg_ext;
  logic [CW-1:0]              w_eff;
  swm_upd_t                   upd;

  logic [WINDOW_MAX-1:0][SAMPLE_W-1:0] cell_vals;
  swm_link_t                           links [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0]          lo_val;
  logic signed [SAMPLE_W-1:0]          hi_val;

  // Window bookkeeping for the update cycle.
  always_comb begin
    full    = fill_r == w_r;
    bcount  = full ? fill_r - CW'(1) : fill_r;
    pos_inc = CW'(pos_r) + CW'(1);
    emit    = full || (fill_r + CW'(1) == w_r);
    rd_addr = in_bus.restart ? '0 : pos_r;
  end

  // Effective window size from a configuration write.
  always_comb begin
    cfg_ext = XW'(cfg_wdata);
    if (cfg_ext == '0) begin
      w_eff = CW'(1);
    end else if (cfg_ext > XW'(WINDOW_MAX)) begin
      w_eff = CW'(WINDOW_MAX);
    end else begin
      w_eff = CW'(cfg_ext);
    end
  end

  // Next-state logic of the item sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_bus.valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = emit ? ST_PICK1 : ST_IDLE;
      end
      ST_PICK1: begin
        state_nxt = ST_PICK2;
      end
      ST_PICK2: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (!out_valid_r || out_bus.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output decode of the item sequencer.
  always_comb begin
    in_bus.ready = 1'b0;
    upd_load     = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE:   in_bus.ready = 1'b1;
      ST_UPDATE: upd_load     = 1'b1;
      ST_SUM:    out_load     = !out_valid_r || out_bus.ready;
      default: begin
        in_bus.ready = 1'b0;
      end
    endcase
  end

  assign in_take = in_bus.valid && in_bus.ready;
  assign upd     = '{load: upd_load, full: full, rem_val: ring_q_r, ins_val: sample_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      w_r         <= CW'(1);
      lo_r        <= '0;
      hi_r        <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        w_r    <= w_eff;
        lo_r   <= AW'((w_eff - CW'(1)) >> 1);
        hi_r   <= AW'(w_eff >> 1);
        fill_r <= '0;
        pos_r  <= '0;
      end else if (in_take && in_bus.restart) begin
        fill_r <= '0;
        pos_r  <= '0;
      end else if (upd.load) begin
        if (!full) begin
          fill_r <= fill_r + CW'(1);
        end
        pos_r <= (pos_inc == w_r) ? '0 : AW'(pos_inc);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample latch and arrival ring: read the oldest slot on the input beat,
  // write the new sample into that slot during the update.
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r <= in_bus.sample;
      ring_q_r <= ring_mem[rd_addr];
    end
    if (upd.load) begin
      ring_mem[pos_r] <= sample_r;
    end
  end

  // Row of sorted cells.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_link_t                  prev_link;
    logic signed [SAMPLE_W-1:0] next_val;
    logic signed [SAMPLE_W-1:0] own_val;

    if (i == 0) begin : g_first
      assign prev_link = '{le: 1'b1, val: '0};
    end else begin : g_rest
      assign prev_link = links[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign next_val = own_val;
    end else begin : g_inner
      assign next_val = $signed(cell_vals[i+1]);
    end

    swm_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .upd       (upd),
      .bcount    (bcount),
      .next_val  (next_val),
      .prev_link (prev_link),
      .val       (own_val),
      .link      (links[i])
    );

    assign cell_vals[i] = own_val;
  end

  // Median readout.
  swm_pick #(
    .WMAX (WINDOW_MAX),
    .AW   (AW)
  ) u_pick (
    .clk    (clk),
    .vals   (cell_vals),
    .lo_idx (lo_r),
    .hi_idx (hi_r),
    .lo_val (lo_val),
    .hi_val (hi_val)
  );

  // Output register: sum of the two middle samples.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.median_doubled = out_data_r;

  // The window never holds more samples than its size, and the ring slot stays inside it.
  `SWM_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= w_r)
  `SWM_ASSERT_NOW(a_pos_bound, 1'b1, CW'(pos_r) < w_r)
  // A readout starts only when the update left the window full.
  `SWM_ASSERT_NEXT(a_pick_full, state_r == ST_UPDATE && emit, fill_r == w_r)
  // A new result appears only out of the add cycle.
  `SWM_ASSERT_NOW(a_out_from_sum, $rose(out_valid_r), $past(state_r) == ST_SUM)

endmodule

// File: tb/sv/swm_median_checker.sv
// Checker for the sliding-window median filter: watches both channels and the
// configuration port, predicts each doubled median and compares it with the result beat.
// Depends on swm_pkg, swm_in_if and swm_out_if.
module swm_median_checker #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  swm_in_if                         in_mon,
  swm_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
  output int                        error_count,
  output int                        pending_count
);
  import swm_pkg::*;

  // Shadow copy of the window: arrival order and ascending order.
  int signed           ring_copy [WINDOW_MAX];
  int signed           sorted_copy [WINDOW_MAX];
  int unsigned         held;
  int unsigned         oldest_slot;
  logic [CFG_W-1:0]    window_reg;
  logic signed [OUT_W-1:0] medians_due [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // A written value of zero acts as one; values past the store size saturate.
  function automatic int unsigned span_in_use();
    if (window_reg == '0) return 1;
    if (window_reg > WINDOW_MAX) return WINDOW_MAX;
    return window_reg;
  endfunction

  // Drop one copy of the given value from the sorted copy.
  task automatic drop_sorted(input int signed v);
    int unsigned i;
    i = 0;
    while (i < held && sorted_copy[i] != v) i++;
    if (i < held) begin
      while (i + 1 < held) begin
        sorted_copy[i] = sorted_copy[i + 1];
        i++;
      end
      held--;
    end
  endtask

  // Insert a value at its ascending position.
  task automatic place_sorted(input int signed v);
    int unsigned i;
    i = held;
    while (i > 0 && sorted_copy[i - 1] > v) begin
      sorted_copy[i] = sorted_copy[i - 1];
      i--;
    end
    sorted_copy[i] = v;
    held++;
  endtask

  // Take one sample into the window and work out the doubled median, if any.
  task automatic slide_window(input logic signed [SAMPLE_W-1:0] s, input logic restart,
                              output bit yields, output logic signed [OUT_W-1:0] med);
    int unsigned w;
    logic signed [OUT_W-1:0] lo;
    logic signed [OUT_W-1:0] hi;
    w = span_in_use();
    if (restart || held > w) begin
      held        = 0;
      oldest_slot = 0;
    end
    if (held == w) drop_sorted(ring_copy[oldest_slot % w]);
    place_sorted(s);
    ring_copy[oldest_slot % w] = s;
    oldest_slot = (oldest_slot + 1) % w;
    yields = (held >= w);
    med    = '0;
    if (yields) begin
      if (w % 2 == 1) begin
        lo = sorted_copy[(w - 1) / 2];
        hi = lo;
      end else begin
        lo = sorted_copy[w / 2 - 1];
        hi = sorted_copy[w / 2];
      end
      med = lo + hi;
    end
  endtask

  // Per clock edge: reset, register writes, result beats, then sample beats.
  always @(posedge clk) begin : watch
    bit                      yields;
    logic signed [OUT_W-1:0] med;
    logic signed [OUT_W-1:0] want;
    if (!rst_n) begin
      window_reg  = CFG_W'(1);
      held        = 0;
      oldest_slot = 0;
      medians_due.delete();
    end else begin
      if (cfg_we) begin
        window_reg  = cfg_wdata;
        held        = 0;
        oldest_slot = 0;
      end
      // A result beat always belongs to a sample taken at an earlier edge.
      if (out_mon.valid && out_mon.ready) begin
        if (medians_due.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected",
                                    out_mon.median_doubled));
        end else begin
          want = medians_due.pop_front();
          if (out_mon.median_doubled !== want)
            report_mismatch($sformatf("median_doubled got %0d, expected %0d",
                                      out_mon.median_doubled, want));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        slide_window(in_mon.sample, in_mon.restart, yields, med);
        if (yields) medians_due.push_back(med);
      end
    end
    pending_count = medians_due.size();
  end

endmodule

// File: tb/sv/sliding_window_median_top_tb.sv
// Top of the sliding-window median filter testbench: clock, reset, stimulus and verdict.
// Depends on swm_pkg, swm_in_if, swm_out_if, swm_median_checker and the filter itself.
module sliding_window_median_top_tb;
  import swm_pkg::*;

  localparam int WMAX         = WINDOW_MAX_DEF;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 10;
  localparam int RANDOM_SPAN  = -1;

  // Idling modes.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  // Random phases: window written, beats sent, idling mode.
  localparam int PHASE_WIN   [PHASES] = '{127, 5, 2, 65, 0, 9, 64, 3, RANDOM_SPAN, 33};
  localparam int PHASE_ITEMS [PHASES] = '{70, 60, 60, 70, 50, 60, 70, 60, 60, 70};
  localparam int PHASE_IDLE  [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                          IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_NONE,
                                          IDLE_BOTH, IDLE_RECV};
  localparam int PRESSURE_PHASE = 7;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               errors;
  int               pending;
  int               tx_idle_pct;
  int               rx_stall_pct;
  int               cycles;
  bit               holding;
  event             hold_start;

  swm_in_if  in_bus ();
  swm_out_if out_bus ();

  sliding_window_median_top #(.WINDOW_MAX(WMAX)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  swm_median_checker #(.WINDOW_MAX(WMAX)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .error_count   (errors),
    .pending_count (pending)
  );

  always #4 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Long receiver hold-off, counted on rising edges so the ready driver sees a stable flag.
  always begin
    @(hold_start);
    @(posedge clk);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  // Receiver: ready changes at the falling edge.
  always @(negedge clk) begin
    if (holding) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic set_idling(input int mode);
    tx_idle_pct  = (mode == IDLE_SEND) ? 47 : (mode == IDLE_BOTH) ? 22 : 0;
    rx_stall_pct = (mode == IDLE_RECV) ? 47 : (mode == IDLE_BOTH) ? 22 : 0;
  endtask

  // Offer one sample beat; called and returns at a falling edge, valid left high.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.sample  <= s;
    in_bus.restart <= restart;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected median is in, plus the pipeline tail.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_window(input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Mix of extremes, a narrow band that makes duplicates, and full-range values.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $signed($urandom_range(8)) - 4;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    in_bus.restart = 1'b0;
    out_bus.ready  = 1'b0;
    holding        = 1'b0;
    cycles         = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: window of one straight out of reset, field extremes.
    set_idling(IDLE_BOTH);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0000_0000, 1'b1);
    send_sample(32'shFFFF_FFFF, 1'b0);
    // Even window: largest and smallest sums, restart while the window is full.
    write_window(2);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sd5, 1'b1);
    send_sample(32'sd5, 1'b0);
    // Odd window with equal samples being evicted.
    write_window(3);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd3, 1'b0);
    // A written zero behaves as a window of one.
    write_window(0);
    send_sample(32'sd9, 1'b0);
    send_sample(-32'sd11, 1'b1);

    // Random phases over several window settings and idling modes.
    for (int p = 0; p < PHASES; p++) begin
      int win;
      int span;
      int restart_pct;
      win = (PHASE_WIN[p] == RANDOM_SPAN) ? $urandom_range(16, 1) : PHASE_WIN[p];
      write_window(win);
      set_idling(PHASE_IDLE[p]);
      span        = (win == 0) ? 1 : (win > WMAX) ? WMAX : win;
      restart_pct = (span > 16) ? 1 : 4;
      if (p == PRESSURE_PHASE) -> hold_start;
      for (int k = 0; k < PHASE_ITEMS[p]; k++)
        send_sample(pick_sample(), $urandom_range(99) < restart_pct);
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
